/* rtl/abc_pkg.sv */
// Shared constants, codes and item types of the alignment block chainer.
package abc_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int COORD_W    = 31;
  localparam int TGS_W      = 17;
  localparam int WEIGHT_W   = COORD_W + IDX_W;
  localparam int NUM_W      = 10;

  localparam logic [COORD_W-1:0] GAP_RESET     = COORD_W'(5000);
  localparam logic [COORD_W-1:0] BREADTH_RESET = COORD_W'(5000);

  localparam logic CFG_MAX_GAP     = 1'b0;
  localparam logic CFG_MIN_BREADTH = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [COORD_W-1:0] q_start;
    logic [COORD_W-1:0] q_end;
    logic [COORD_W-1:0] t_start;
    logic [COORD_W-1:0] t_end;
    logic [15:0]        target_id;
    logic               strand;
    logic [COORD_W-1:0] aligned_size;
    logic               last_block;
  } in_item_t;

  typedef struct packed {
    logic [NUM_W-1:0]   block_number;
    logic [COORD_W-1:0] out_q_start;
    logic [COORD_W-1:0] out_q_end;
    logic [COORD_W-1:0] out_t_start;
    logic [COORD_W-1:0] out_t_end;
    logic               last_in_chain;
    logic               none_left;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] qs;
    logic [COORD_W-1:0] qe;
    logic [COORD_W-1:0] ts;
    logic [COORD_W-1:0] te;
    logic [TGS_W-1:0]   tgs;
    logic [COORD_W-1:0] size;
    logic [IDX_W-1:0]   order;
  } block_t;

  typedef struct packed {
    logic                taken;
    logic [CNT_W-1:0]    epoch;
    logic [WEIGHT_W-1:0] weight;
    logic                prev_valid;
    logic [IDX_W-1:0]    prev_idx;
  } vertex_t;

  typedef struct packed {
    logic chain_ik;
    logic chain_fk;
    logic after_key;
  } link_t;

endpackage

/* rtl/abc_if.sv */
// Request and response channel interfaces of the alignment block chainer.
interface abc_req_if import abc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface abc_rsp_if import abc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/abc_ram.sv */
// Generic single write port RAM with registered read.
module abc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/abc_link_unit.sv */
// Shared compare unit: chain tests against two held blocks and the sort order test.
module abc_link_unit import abc_pkg::*; (
  input  block_t             blk_i,
  input  block_t             blk_f,
  input  block_t             blk_k,
  input  block_t             key,
  input  logic [COORD_W-1:0] gap,
  output link_t              link
);
  logic [COORD_W:0] dq_i, dt_i, dq_f, dt_f;

  // signed gaps between the end of a held block and the start of the read block
  assign dq_i = {1'b0, blk_k.qs} - {1'b0, blk_i.qe};
  assign dt_i = {1'b0, blk_k.ts} - {1'b0, blk_i.te};
  assign dq_f = {1'b0, blk_k.qs} - {1'b0, blk_f.qe};
  assign dt_f = {1'b0, blk_k.ts} - {1'b0, blk_f.te};

  assign link.chain_ik = (blk_i.tgs == blk_k.tgs) &&
                         !dq_i[COORD_W] && (dq_i[COORD_W-1:0] < gap) &&
                         !dt_i[COORD_W] && (dt_i[COORD_W-1:0] < gap);
  assign link.chain_fk = (blk_f.tgs == blk_k.tgs) &&
                         !dq_f[COORD_W] && (dq_f[COORD_W-1:0] < gap) &&
                         !dt_f[COORD_W] && (dt_f[COORD_W-1:0] < gap);
  // stored block sorts after the new key
  assign link.after_key = (blk_k.qs > key.qs) || ((blk_k.qs == key.qs) && (blk_k.ts > key.ts));
endmodule

/* rtl/alignment_block_chainer.sv */
// Top level: block store, sequencer for sorting, chaining rounds and read-out.
//
//   channel | dir | beat
//   req     | in  | load one block or pull one chain member
//   rsp     | out | one chain member or none_left per pull
//   cfg     | in  | register write, no read-back
//
// A load holds req off while each stored block that sorts after it moves up one place,
// until the shift reaches the bottom of the store or a block that does not sort after it.
// A final load then runs a clear sweep, and per round a weighing pass over (i, k) pairs,
// a best pick, a trace back and an emit of each member of a broad enough chain. A pull
// reads the chain entry, then the block fields (neither with nothing left), and waits while rsp stalls.
// Reset is synchronous and clears counters; store contents are undefined until written.
// req is held off while any item is at work; a stalled rsp beat holds the next pull.
module alignment_block_chainer import abc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  abc_req_if.sink            req,
  abc_rsp_if.source          rsp,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [COORD_W-1:0] cfg_data
);
  typedef enum logic [4:0] {
    S_IDLE, S_L_RD, S_L_CMP, S_L_PUT, S_C_CLR, S_R_START, S_W_I_RD, S_W_I_EV,
    S_W_K_RD, S_W_K_EV, S_B_RD, S_B_EV, S_B_END, S_T_RD, S_T_EV, S_T_CHK,
    S_E_RD, S_E_WR, S_R_NEXT, S_FIN, S_P_CL, S_P_BL, S_P_PUT
  } state_t;

  state_t              state;
  logic [COORD_W-1:0]  gap, min_b;
  logic [CNT_W-1:0]    block_count, emit_count, rp;
  logic [CNT_W-1:0]    i, k, len, e, round, taken_cnt;
  logic [IDX_W-1:0]    cur, best;
  logic                have_first, have, last_flag, end_flag;
  logic [WEIGHT_W-1:0] wi, bw;
  block_t              bi, bf, nb;
  logic [COORD_W-1:0]  tail_qe, tail_te, head_qs, head_ts;
  out_item_t           pend, res;
  logic                out_valid;

  logic                b_we, v_we, t_we, c_we;
  logic [IDX_W-1:0]    b_waddr, b_raddr, v_waddr, v_raddr, t_waddr, t_raddr, c_waddr;
  block_t              b_wdata, b_rdata;
  vertex_t             v_wdata, v_rdata;
  logic [IDX_W-1:0]    t_wdata, t_rdata;
  logic [IDX_W:0]      c_wdata, c_rdata;
  link_t               link;
  logic [WEIGHT_W-1:0] alt;
  logic                relax_go;
  logic [CNT_W-1:0]    k_m1, e_m1, len_p1;
  logic [COORD_W:0]    qlen, tlen;
  logic                wide_ok;

  abc_ram #(.WIDTH($bits(block_t)), .DEPTH(MAX_BLOCKS)) u_blocks (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(b_raddr), .rdata(b_rdata));
  abc_ram #(.WIDTH($bits(vertex_t)), .DEPTH(MAX_BLOCKS)) u_vertex (
    .clk, .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(v_raddr), .rdata(v_rdata));
  abc_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BLOCKS)) u_trace (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata));
  abc_ram #(.WIDTH(IDX_W + 1), .DEPTH(MAX_BLOCKS)) u_chains (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(rp[IDX_W-1:0]),
    .rdata(c_rdata));

  abc_link_unit u_link (
    .blk_i(bi), .blk_f(bf), .blk_k(b_rdata), .key(nb), .gap(gap), .link(link));

  // derived values
  assign k_m1     = k - CNT_W'(1);
  assign e_m1     = e - CNT_W'(1);
  assign len_p1   = len + CNT_W'(1);
  assign alt      = wi + WEIGHT_W'(b_rdata.size);
  assign relax_go = link.chain_ik && (!have_first || !link.chain_fk) && !v_rdata.taken &&
                    ((v_rdata.epoch != round) || (v_rdata.weight < alt));
  assign qlen     = {1'b0, tail_qe} - {1'b0, head_qs};
  assign tlen     = {1'b0, tail_te} - {1'b0, head_ts};
  assign wide_ok  = !qlen[COORD_W] && (qlen[COORD_W-1:0] >= min_b) &&
                    !tlen[COORD_W] && (tlen[COORD_W-1:0] >= min_b);

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = res;

  // steer memory ports
  always_comb begin
    b_we = 1'b0; b_waddr = k[IDX_W-1:0]; b_wdata = nb; b_raddr = i[IDX_W-1:0];
    v_we = 1'b0; v_waddr = i[IDX_W-1:0]; v_wdata = '0; v_raddr = i[IDX_W-1:0];
    t_we = 1'b0; t_waddr = len[IDX_W-1:0]; t_wdata = cur; t_raddr = e_m1[IDX_W-1:0];
    c_we = 1'b0; c_waddr = emit_count[IDX_W-1:0]; c_wdata = {t_rdata, e == CNT_W'(1)};
    case (state)
      S_L_RD:   b_raddr = k_m1[IDX_W-1:0];
      S_L_CMP:  begin
        b_we = link.after_key;
        b_wdata = b_rdata;
      end
      S_L_PUT:  b_we = 1'b1;
      S_C_CLR:  v_we = (i != block_count);
      S_W_I_EV: begin
        v_we = !v_rdata.taken && (v_rdata.epoch != round);
        v_wdata = '{taken: 1'b0, epoch: round, weight: WEIGHT_W'(b_rdata.size),
                    prev_valid: 1'b0, prev_idx: '0};
      end
      S_W_K_RD: begin
        b_raddr = k[IDX_W-1:0];
        v_raddr = k[IDX_W-1:0];
      end
      S_W_K_EV: begin
        v_we = relax_go;
        v_waddr = k[IDX_W-1:0];
        v_wdata = '{taken: 1'b0, epoch: round, weight: alt,
                    prev_valid: 1'b1, prev_idx: i[IDX_W-1:0]};
      end
      S_T_RD:   begin
        b_raddr = cur;
        v_raddr = cur;
      end
      S_T_EV:   begin
        t_we = 1'b1;
        v_we = !v_rdata.taken;
        v_waddr = cur;
        v_wdata = v_rdata;
        v_wdata.taken = 1'b1;
      end
      S_E_WR:   c_we = 1'b1;
      S_P_CL:   b_raddr = c_rdata[IDX_W:1];
      default:  ;
    endcase
  end

  // sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      gap <= GAP_RESET;
      min_b <= BREADTH_RESET;
      block_count <= '0;
      emit_count <= '0;
      rp <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_GAP:     gap <= cfg_data;
          CFG_MIN_BREADTH: min_b <= cfg_data;
          default:         ;
        endcase
      end
      // drop the beat once taken, unless a new one is put out this cycle
      if (rsp.ready && (state != S_P_PUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (req.data.operation == OP_LOAD) begin
              emit_count <= '0;
              rp <= '0;
              last_flag <= req.data.last_block;
              nb <= '{qs: req.data.q_start, qe: req.data.q_end, ts: req.data.t_start,
                      te: req.data.t_end, tgs: {req.data.target_id, req.data.strand},
                      size: req.data.aligned_size, order: block_count[IDX_W-1:0]};
              k <= block_count;
              i <= '0;
              if (block_count < CNT_W'(MAX_BLOCKS)) begin
                state <= S_L_RD;
              end else if (req.data.last_block) begin
                state <= S_C_CLR;
              end
            end else if (rp >= emit_count) begin
              pend <= '{none_left: 1'b1, default: '0};
              state <= S_P_PUT;
            end else begin
              rp <= rp + CNT_W'(1);
              state <= S_P_CL;
            end
          end
        end
        // insertion: shift larger blocks up one place
        S_L_RD:  state <= (k == '0) ? S_L_PUT : S_L_CMP;
        S_L_CMP: begin
          if (link.after_key) begin
            k <= k_m1;
            state <= S_L_RD;
          end else begin
            state <= S_L_PUT;
          end
        end
        S_L_PUT: begin
          block_count <= block_count + CNT_W'(1);
          i <= '0;
          state <= last_flag ? S_C_CLR : S_IDLE;
        end
        // clear vertex state
        S_C_CLR: begin
          if (i == block_count) begin
            taken_cnt <= '0;
            round <= CNT_W'(1);
            state <= S_R_START;
          end else begin
            i <= i + CNT_W'(1);
          end
        end
        S_R_START: begin
          i <= '0;
          state <= (taken_cnt < block_count) ? S_W_I_RD : S_FIN;
        end
        // weighing pass
        S_W_I_RD: begin
          if (i == block_count) begin
            i <= '0;
            have <= 1'b0;
            bw <= '0;
            best <= '0;
            state <= S_B_RD;
          end else begin
            state <= S_W_I_EV;
          end
        end
        S_W_I_EV: begin
          if (v_rdata.taken) begin
            i <= i + CNT_W'(1);
            state <= S_W_I_RD;
          end else begin
            bi <= b_rdata;
            wi <= (v_rdata.epoch != round) ? WEIGHT_W'(b_rdata.size) : v_rdata.weight;
            have_first <= 1'b0;
            k <= i + CNT_W'(1);
            state <= S_W_K_RD;
          end
        end
        S_W_K_RD: begin
          if (k == block_count) begin
            i <= i + CNT_W'(1);
            state <= S_W_I_RD;
          end else begin
            state <= S_W_K_EV;
          end
        end
        S_W_K_EV: begin
          if (link.chain_ik && have_first && link.chain_fk) begin
            i <= i + CNT_W'(1);
            state <= S_W_I_RD;
          end else begin
            if (link.chain_ik && !have_first) begin
              have_first <= 1'b1;
              bf <= b_rdata;
            end
            k <= k + CNT_W'(1);
            state <= S_W_K_RD;
          end
        end
        // pick the last heaviest vertex
        S_B_RD: state <= (i == block_count) ? S_B_END : S_B_EV;
        S_B_EV: begin
          if (!v_rdata.taken && (v_rdata.epoch == round) && (!have || v_rdata.weight >= bw))
          begin
            have <= 1'b1;
            bw <= v_rdata.weight;
            best <= i[IDX_W-1:0];
          end
          i <= i + CNT_W'(1);
          state <= S_B_RD;
        end
        S_B_END: begin
          cur <= best;
          len <= '0;
          state <= have ? S_T_RD : S_FIN;
        end
        // trace back and mark taken
        S_T_RD: state <= S_T_EV;
        S_T_EV: begin
          if (len == '0) begin
            tail_qe <= b_rdata.qe;
            tail_te <= b_rdata.te;
          end
          head_qs <= b_rdata.qs;
          head_ts <= b_rdata.ts;
          len <= len_p1;
          if (!v_rdata.taken) begin
            taken_cnt <= taken_cnt + CNT_W'(1);
          end
          if (!v_rdata.prev_valid || len_p1 >= CNT_W'(MAX_BLOCKS)) begin
            state <= S_T_CHK;
          end else begin
            cur <= v_rdata.prev_idx;
            state <= S_T_RD;
          end
        end
        S_T_CHK: begin
          e <= len;
          state <= wide_ok ? S_E_RD : S_R_NEXT;
        end
        // emit head first
        S_E_RD: begin
          state <= ((e == '0) || (emit_count >= CNT_W'(MAX_BLOCKS))) ? S_R_NEXT : S_E_WR;
        end
        S_E_WR: begin
          emit_count <= emit_count + CNT_W'(1);
          e <= e_m1;
          state <= S_E_RD;
        end
        S_R_NEXT: begin
          round <= round + CNT_W'(1);
          state <= S_R_START;
        end
        S_FIN: begin
          block_count <= '0;
          state <= S_IDLE;
        end
        // pull: chain entry, then block fields
        S_P_CL: begin
          end_flag <= c_rdata[0];
          state <= S_P_BL;
        end
        S_P_BL: begin
          pend <= '{block_number: NUM_W'(b_rdata.order), out_q_start: b_rdata.qs,
                    out_q_end: b_rdata.qe, out_t_start: b_rdata.ts, out_t_end: b_rdata.te,
                    last_in_chain: end_flag, none_left: 1'b0};
          state <= S_P_PUT;
        end
        S_P_PUT: begin
          if (!out_valid || rsp.ready) begin
            res <= pend;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    emit_count <= CNT_W'(MAX_BLOCKS)) else $error("emit count overflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    block_count <= CNT_W'(MAX_BLOCKS)) else $error("block count overflow");
  a_taken_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_R_START) |-> (taken_cnt <= block_count)) else $error("taken count high");
  a_rp_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_P_CL) |-> (rp <= emit_count)) else $error("pull beyond emitted list");
`endif
endmodule

/* bench/testbench.sv */
// Self-checking bench for the alignment block chainer: directed table, then random batches.
module testbench;
  import abc_pkg::*;

  localparam int IN_W = $bits(in_item_t);

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic               cfg_index;
  logic [COORD_W-1:0] cfg_data;

  abc_req_if req ();
  abc_rsp_if rsp ();

  alignment_block_chainer dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Chaining predictor state
  logic [COORD_W-1:0] gap_reg;
  logic [COORD_W-1:0] breadth_reg;
  block_t             blocks [MAX_BLOCKS];
  longint             path_w [MAX_BLOCKS];
  bit                 back_ok [MAX_BLOCKS];
  int                 back_idx [MAX_BLOCKS];
  bit                 used [MAX_BLOCKS];
  bit                 seen [MAX_BLOCKS];
  int                 trail [MAX_BLOCKS];
  int                 member_idx [MAX_BLOCKS];
  bit                 member_end [MAX_BLOCKS];
  int                 n_blocks;
  int                 n_members;
  int                 read_pos;

  out_item_t member_q[$];
  int        fail_count;
  int        beats_in;
  int        beats_out;
  int        chains_made;
  longint    cycle_count = 0;
  bit        quiet;
  int        stall_left;

  // Block a may be followed by block b
  function automatic bit follows(int a, int b);
    longint dq, dt;
    if (blocks[a].tgs != blocks[b].tgs) return 0;
    dq = longint'(blocks[b].qs) - longint'(blocks[a].qe);
    dt = longint'(blocks[b].ts) - longint'(blocks[a].te);
    return dq >= 0 && dq < longint'(gap_reg) && dt >= 0 && dt < longint'(gap_reg);
  endfunction

  // One heaviest-path pass over blocks not yet taken
  function automatic void weigh_blocks();
    int first;
    bit have_first;
    longint alt;
    for (int i = 0; i < n_blocks; i++) seen[i] = 0;
    for (int i = 0; i < n_blocks; i++) begin
      if (used[i]) continue;
      if (!seen[i]) begin
        seen[i] = 1;
        path_w[i] = blocks[i].size;
        back_ok[i] = 0;
      end
      have_first = 0;
      first = 0;
      for (int k = i + 1; k < n_blocks; k++) begin
        if (!follows(i, k)) continue;
        if (!have_first) begin
          have_first = 1;
          first = k;
        end else if (follows(first, k)) begin
          break;
        end
        if (used[k]) continue;
        alt = path_w[i] + blocks[k].size;
        if (!seen[k] || path_w[k] < alt) begin
          seen[k] = 1;
          path_w[k] = alt;
          back_ok[k] = 1;
          back_idx[k] = i;
        end
      end
    end
  endfunction

  // Rounds of pick, trace back and emit of broad enough chains until every block is taken
  function automatic void chain_blocks();
    int ntaken, best, len, cur, head, tail;
    longint bw, qspan, tspan;
    bit have;
    ntaken = 0;
    for (int i = 0; i < MAX_BLOCKS; i++) used[i] = 0;
    n_members = 0;
    read_pos = 0;
    while (ntaken < n_blocks) begin
      weigh_blocks();
      have = 0;
      best = 0;
      bw = 0;
      for (int i = 0; i < n_blocks; i++) begin
        if (used[i] || !seen[i]) continue;
        if (!have || path_w[i] >= bw) begin
          have = 1;
          bw = path_w[i];
          best = i;
        end
      end
      if (!have) break;
      len = 0;
      cur = best;
      forever begin
        trail[len++] = cur;
        if (!used[cur]) begin
          used[cur] = 1;
          ntaken++;
        end
        if (!back_ok[cur] || len >= MAX_BLOCKS) break;
        cur = back_idx[cur];
      end
      head = trail[len-1];
      tail = trail[0];
      qspan = longint'(blocks[tail].qe) - longint'(blocks[head].qs);
      tspan = longint'(blocks[tail].te) - longint'(blocks[head].ts);
      if (qspan >= longint'(breadth_reg) && tspan >= longint'(breadth_reg)) begin
        chains_made++;
        for (int i = len; i > 0; i--) begin
          if (n_members >= MAX_BLOCKS) break;
          member_idx[n_members] = trail[i-1];
          member_end[n_members] = (i == 1);
          n_members++;
        end
      end
    end
    n_blocks = 0;
  endfunction

  // Insert a block in sorted position, then chain on the final load
  function automatic void load_block(in_item_t it);
    int p;
    n_members = 0;
    read_pos = 0;
    if (n_blocks < MAX_BLOCKS) begin
      p = n_blocks;
      while (p > 0 && (blocks[p-1].qs > it.q_start ||
             (blocks[p-1].qs == it.q_start && blocks[p-1].ts > it.t_start)))
        p--;
      for (int k = n_blocks; k > p; k--) blocks[k] = blocks[k-1];
      blocks[p].qs = it.q_start;
      blocks[p].qe = it.q_end;
      blocks[p].ts = it.t_start;
      blocks[p].te = it.t_end;
      blocks[p].tgs = {it.target_id, it.strand};
      blocks[p].size = it.aligned_size;
      blocks[p].order = IDX_W'(n_blocks);
      n_blocks++;
    end
    if (it.last_block) chain_blocks();
  endfunction

  function automatic out_item_t next_member();
    out_item_t o;
    int idx;
    o = '0;
    if (read_pos >= n_members) begin
      o.none_left = 1'b1;
      return o;
    end
    idx = member_idx[read_pos];
    o.block_number = blocks[idx].order;
    o.out_q_start = blocks[idx].qs;
    o.out_q_end = blocks[idx].qe;
    o.out_t_start = blocks[idx].ts;
    o.out_t_end = blocks[idx].te;
    o.last_in_chain = member_end[read_pos];
    read_pos++;
    return o;
  endfunction

  // Clock and cycle limit
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // Response side: random stall bursts, none once quiet
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_left <= 0;
    end else if (quiet) begin
      rsp.ready <= 1'b1;
    end else if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      rsp.ready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Check each response beat against the oldest expected member
  always @(posedge clk) begin
    out_item_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = rsp.data;
      beats_out++;
      if (member_q.size() == 0) begin
        $error("Response beat with nothing expected");
        fail_count++;
      end else begin
        want = member_q.pop_front();
        if (got.block_number !== want.block_number) begin
          $error("block_number exp %0d got %0d", want.block_number, got.block_number);
          fail_count++;
        end
        if (got.out_q_start !== want.out_q_start) begin
          $error("out_q_start exp %0d got %0d", want.out_q_start, got.out_q_start);
          fail_count++;
        end
        if (got.out_q_end !== want.out_q_end) begin
          $error("out_q_end exp %0d got %0d", want.out_q_end, got.out_q_end);
          fail_count++;
        end
        if (got.out_t_start !== want.out_t_start) begin
          $error("out_t_start exp %0d got %0d", want.out_t_start, got.out_t_start);
          fail_count++;
        end
        if (got.out_t_end !== want.out_t_end) begin
          $error("out_t_end exp %0d got %0d", want.out_t_end, got.out_t_end);
          fail_count++;
        end
        if (got.last_in_chain !== want.last_in_chain) begin
          $error("last_in_chain exp %0d got %0d", want.last_in_chain, got.last_in_chain);
          fail_count++;
        end
        if (got.none_left !== want.none_left) begin
          $error("none_left exp %0d got %0d", want.none_left, got.none_left);
          fail_count++;
        end
      end
    end
  end

  // Send one beat, then update the predictor; a typed expectation overrides it on pulls
  task automatic put_item(in_item_t it, bit typed, out_item_t typed_exp);
    out_item_t pred;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data <= it;
    do @(posedge clk); while (!req.ready);
    beats_in++;
    if (it.operation == OP_LOAD) begin
      load_block(it);
    end else begin
      pred = next_member();
      member_q.insert(member_q.size(), typed ? typed_exp : pred);
    end
  endtask

  // Write a register once every expected member has arrived
  task automatic write_reg(logic idx, logic [COORD_W-1:0] val);
    req.valid <= 1'b0;
    wait (member_q.size() == 0);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_GAP) gap_reg = val;
    else breadth_reg = val;
  endtask

  function automatic in_item_t mk_load(int qs, int qe, int ts, int te, int tid, bit s,
                                       int sz, bit last);
    in_item_t it;
    it.operation = OP_LOAD;
    it.q_start = COORD_W'(qs);
    it.q_end = COORD_W'(qe);
    it.t_start = COORD_W'(ts);
    it.t_end = COORD_W'(te);
    it.target_id = 16'(tid);
    it.strand = s;
    it.aligned_size = COORD_W'(sz);
    it.last_block = last;
    return it;
  endfunction

  function automatic in_item_t mk_pull();
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom()}));
    it.operation = OP_PULL;
    return it;
  endfunction

  // One random batch: mostly chainable runs, some noise, stray pulls
  task automatic run_batch();
    int n, tid, qs, ts, step;
    bit s;
    in_item_t it;
    out_item_t nothing;
    nothing = '0;
    n = $urandom_range(1, 9);
    tid = $urandom_range(0, 3);
    s = $urandom_range(0, 1);
    qs = $urandom_range(0, 1 << 29);
    ts = $urandom_range(0, 1 << 29);
    for (int b = 0; b < n; b++) begin
      if ($urandom_range(0, 4) == 0) begin
        it = mk_load($urandom() & 32'h7fffffff, $urandom() & 32'h7fffffff,
                     $urandom() & 32'h7fffffff, $urandom() & 32'h7fffffff,
                     $urandom_range(0, 65535), $urandom_range(0, 1),
                     $urandom() & 32'h7fffffff, b == n - 1);
      end else begin
        case ($urandom_range(0, 3))
          0: step = 0;
          1: step = (gap_reg > 0) ? gap_reg - 1 : 0;
          2: step = gap_reg;
          default: step = $urandom_range(0, 3000);
        endcase
        if (step > 2000000) step = $urandom_range(0, 5000);
        it = mk_load(qs, qs + $urandom_range(0, 4000), ts, ts + $urandom_range(0, 4000),
                     ($urandom_range(0, 5) == 0) ? tid + 1 : tid,
                     ($urandom_range(0, 7) == 0) ? !s : s,
                     $urandom_range(1, 3000), b == n - 1);
        qs = it.q_end + step;
        ts = it.t_end + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 3000) : step);
        // perturb the query start now and then, which can change the sort order
        if ($urandom_range(0, 3) == 0) begin
          it.q_start = it.q_start ^ COORD_W'($urandom_range(0, 3));
        end
      end
      put_item(it, 0, nothing);
      if ($urandom_range(0, 9) == 0) put_item(mk_pull(), 0, nothing);
    end
    // read out, sometimes leaving members behind for the next load to discard
    for (int p = ($urandom_range(0, 5) == 0) ? 1 : n_members + $urandom_range(1, 2); p > 0; p--)
      put_item(mk_pull(), 0, nothing);
  endtask

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t exp;
  } stim_row_t;

  stim_row_t rows[$];

  // Append one row to the directed table
  function automatic void add_row(in_item_t it, bit typed, out_item_t exp);
    stim_row_t r;
    r.item = it;
    r.typed = typed;
    r.exp = exp;
    rows.insert(rows.size(), r);
  endfunction

  initial begin
    out_item_t none_exp, top_exp, nothing;
    logic [COORD_W-1:0] gaps [5];
    logic [COORD_W-1:0] breadths [5];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_GAP;
    cfg_data = '0;
    req.valid = 1'b0;
    req.data = '0;
    quiet = 0;
    gap_reg = GAP_RESET;
    breadth_reg = BREADTH_RESET;
    n_blocks = 0;
    n_members = 0;
    read_pos = 0;
    nothing = '0;
    none_exp = '0;
    none_exp.none_left = 1'b1;
    top_exp = '0;
    top_exp.out_q_end = '1;
    top_exp.out_t_end = '1;
    top_exp.last_in_chain = 1'b1;

    // Directed table
    add_row(mk_pull(), 1, none_exp);
    add_row(mk_load(3100, 9000, 3200, 9100, 1, 0, 800, 0), 0, nothing);
    add_row(mk_load(100, 3000, 200, 3100, 1, 0, 500, 1), 0, nothing);
    add_row(mk_pull(), 0, nothing);
    add_row(mk_pull(), 0, nothing);
    add_row(mk_pull(), 1, none_exp);
    add_row(mk_load(0, 32'h7fffffff, 0, 32'h7fffffff, 16'hffff, 1, 32'h7fffffff, 1),
            0, nothing);
    add_row(mk_pull(), 1, top_exp);
    add_row(mk_pull(), 1, none_exp);
    add_row(mk_load(10, 7000, 10, 7000, 2, 1, 9, 1), 0, nothing);
    add_row(mk_load(50, 60, 50, 60, 2, 1, 9, 0), 0, nothing);
    add_row(mk_pull(), 1, none_exp);
    add_row(mk_load(50, 60, 50, 60, 2, 1, 9, 0), 0, nothing);
    add_row(mk_load(60, 6000, 60, 6000, 2, 1, 20, 0), 0, nothing);
    add_row(mk_load(62, 6100, 60, 6100, 2, 1, 30, 0), 0, nothing);
    add_row(mk_load(62, 5000, 70, 5000, 3, 0, 40, 1), 0, nothing);
    for (int i = 0; i < 6; i++) add_row(mk_pull(), 0, nothing);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) put_item(rows[i].item, rows[i].typed, rows[i].exp);

    // Random phases over several register settings, extremes among them
    gaps = '{31'd1, 31'h7fffffff, 31'd0, 31'd20000, GAP_RESET};
    breadths = '{31'd0, 31'h7fffffff, 31'd0, 31'd100, BREADTH_RESET};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_MAX_GAP, gaps[ph]);
      write_reg(CFG_MIN_BREADTH, breadths[ph]);
      if (ph == 4) quiet = 1;
      while (beats_in < rows.size() + 22 * (ph + 1)) run_batch();
    end
    put_item(mk_pull(), 0, nothing);
    req.valid <= 1'b0;

    wait (member_q.size() == 0);
    repeat (50) @(posedge clk);
    $display("Sent %0d beats, checked %0d responses, %0d chains emitted over 5 settings",
             beats_in, beats_out, chains_made);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/abc_pkg.sv
rtl/abc_if.sv
rtl/abc_ram.sv
rtl/abc_link_unit.sv
rtl/alignment_block_chainer.sv
bench/testbench.sv
